// File: hw/rtl/metadata_header_parser_crc_unit_assert.svh
// Assertion helpers for the header parser. Expect clk_i and rst_ni in scope.
`ifndef METADATA_HEADER_PARSER_CRC_UNIT_ASSERT_SVH
`define METADATA_HEADER_PARSER_CRC_UNIT_ASSERT_SVH

// Property checked on every clock edge out of reset.
`define MHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define MHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mhp_pkg.sv
`default_nettype none

package mhp_pkg;

  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcInit   = 32'hFFFFFFFF;
  localparam logic [31:0] CrcXorOut = 32'hFFFFFFFF;

  typedef enum logic [0:0] {
    CFG_MAGIC   = 1'b0,
    CFG_VERSION = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_MAGIC   = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_TRUNCATED   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [15:0] name_length;
    logic [63:0] row_total;
    logic [31:0] column_total;
    logic        compressed;
    logic [31:0] stored_crc;
    logic        checksum_ok;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] version;
  } cfg_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mhp_cfg_regs.sv
`default_nettype none

module mhp_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [0:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  output      mhp_pkg::cfg_t cfg_o
);
  import mhp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAGIC:   cfg_q.magic   <= cfg_data_i;
        CFG_VERSION: cfg_q.version <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/mhp_parser.sv
`default_nettype none

module mhp_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire mhp_pkg::in_item_t  item_i,
  input  wire mhp_pkg::cfg_t      cfg_i,
  output      logic               res_valid_o,
  output      mhp_pkg::out_item_t res_o
);
  import mhp_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_VERSION = 4'd1,
    PH_NLEN    = 4'd2,
    PH_NAME    = 4'd3,
    PH_ROWS    = 4'd4,
    PH_COLS    = 4'd5,
    PH_COMP    = 4'd6,
    PH_CRC     = 4'd7,
    PH_DONE    = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] left_q, left_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] crc_q, crc_d;
  logic [15:0] nlen_q, nlen_d;
  logic [63:0] rows_q, rows_d;
  logic [31:0] cols_q, cols_d;
  logic        comp_q, comp_d;
  logic        err_q, err_d;

  logic [7:0]  b;
  logic        last;
  logic        skip;
  logic [63:0] shift_new;
  logic [2:0]  idx_inc;
  logic [2:0]  flen;
  logic        complete;
  status_e     err;

  assign b    = item_i.data_byte;
  assign last = item_i.last_byte;
  assign skip = err_q || (phase_q == PH_DONE);
  assign idx_inc  = idx_q + 3'd1;
  assign complete = (idx_inc == flen);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      shift_new[8*k +: 8] = (idx_q == 3'(k)) ? b : shift_q[8*k +: 8];
    end
  end

  always_comb begin
    case (phase_q)
      PH_MAGIC, PH_VERSION, PH_COLS, PH_CRC: flen = 3'd4;
      PH_NLEN: flen = 3'd2;
      PH_ROWS: flen = 3'd0;
      default: flen = 3'd1;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    left_d  = left_q;
    shift_d = shift_q;
    crc_d   = crc_q;
    nlen_d  = nlen_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    comp_d  = comp_q;
    err_d   = err_q;
    err     = ST_OK;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (!skip) begin
      if (phase_q != PH_CRC) begin
        crc_d = crc_byte(crc_q, b);
      end
      if (phase_q == PH_NAME) begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_NAME;
        res_o.name_char   = b;
        res_o.name_length = nlen_q;
        left_d = left_q - 16'd1;
        if (left_d == 16'd0) begin
          phase_d = PH_ROWS;
        end
      end else if (complete) begin
        idx_d   = '0;
        shift_d = '0;
        case (phase_q)
          PH_MAGIC: begin
            if (shift_new[31:0] != cfg_i.magic) err = ST_BAD_MAGIC;
            else phase_d = PH_VERSION;
          end
          PH_VERSION: begin
            if (shift_new[31:0] != cfg_i.version) err = ST_BAD_VERSION;
            else phase_d = PH_NLEN;
          end
          PH_NLEN: begin
            nlen_d  = shift_new[15:0];
            left_d  = shift_new[15:0];
            phase_d = (shift_new[15:0] != 16'd0) ? PH_NAME : PH_ROWS;
          end
          PH_ROWS: begin
            rows_d  = shift_new;
            phase_d = PH_COLS;
          end
          PH_COLS: begin
            cols_d  = shift_new[31:0];
            phase_d = PH_COMP;
          end
          PH_COMP: begin
            comp_d  = (shift_new[7:0] != 8'd0);
            phase_d = PH_CRC;
          end
          PH_CRC: begin
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_HEADER;
            res_o.name_length  = nlen_q;
            res_o.row_total    = rows_q;
            res_o.column_total = cols_q;
            res_o.compressed   = comp_q;
            res_o.stored_crc   = shift_new[31:0];
            res_o.checksum_ok  = ((crc_q ^ CrcXorOut) == shift_new[31:0]);
            phase_d = PH_DONE;
          end
          default: ;
        endcase
      end else begin
        idx_d   = idx_inc;
        shift_d = shift_new;
      end

      if (err == ST_OK && last && phase_d != PH_DONE) begin
        err = ST_TRUNCATED;
      end
      if (err != ST_OK) begin
        res_valid_o  = 1'b1;
        res_o        = '0;
        res_o.kind   = KIND_ERROR;
        res_o.status = err;
        err_d        = 1'b1;
      end
    end

    if (last) begin
      phase_d = PH_MAGIC;
      idx_d   = '0;
      left_d  = '0;
      shift_d = '0;
      crc_d   = CrcInit;
      nlen_d  = '0;
      rows_d  = '0;
      cols_d  = '0;
      comp_d  = 1'b0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      idx_q   <= '0;
      left_q  <= '0;
      shift_q <= '0;
      crc_q   <= CrcInit;
      nlen_q  <= '0;
      rows_q  <= '0;
      cols_q  <= '0;
      comp_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      shift_q <= shift_d;
      crc_q   <= crc_d;
      nlen_q  <= nlen_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      comp_q  <= comp_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/metadata_header_parser_crc_unit.sv
`default_nettype none
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+----------------------------
// in       | in  | in_valid_i / in_ready_o   | in_data_i (in_item_t)
// out      | out | out_valid_o / out_ready_i | out_data_o (out_item_t)
// cfg      | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle unless the output stalls; each byte is registered, then its result.
// The byte-wise CRC and field assembly sit between the input and result registers.
// rst_ni clears parse state, config registers and both valid flags.
// A stalled result blocks the parse step; the input register still takes one more byte.
// Bytes that give no result still wait for a free result register slot.

module metadata_header_parser_crc_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire mhp_pkg::in_item_t  in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      mhp_pkg::out_item_t out_data_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import mhp_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  logic      advance;
  logic      res_valid;
  out_item_t res;
  logic      out_stall;
  logic      out_err;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_stall   = out_valid_q && !out_ready_i;
  assign out_err     = out_valid_o && (out_data_o.kind == KIND_ERROR);

  mhp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

`include "metadata_header_parser_crc_unit_assert.svh"

  `MHP_ASSERT(a_no_step_on_stall, !(out_stall && advance), "step while stalled")
  `MHP_ASSERT(a_ready_low_cause, in_ready_o || (in_valid_q && out_stall), "bad ready")
  `MHP_ASSERT(a_kind_legal, !out_valid_o || out_data_o.kind <= KIND_ERROR, "illegal kind")
  `MHP_ASSERT(a_err_has_status, !out_err || out_data_o.status != ST_OK, "error without status")
  `MHP_ASSERT_NEXT(a_result_lands, advance && res_valid, out_valid_q, "result lost")

endmodule

`default_nettype wire

// File: sim/metadata_header_parser_crc_unit_tb.sv
`timescale 1ns / 100ps

module metadata_header_parser_crc_unit_tb;
  import mhp_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned IdlePct     = 23;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseBytes  = 110;
  localparam int unsigned NumSettings = 6;
  localparam int unsigned MaxPrinted  = 200;

  typedef enum logic [3:0] {
    PARSE_MAGIC,
    PARSE_VERSION,
    PARSE_NLEN,
    PARSE_NAME,
    PARSE_ROWS,
    PARSE_COLS,
    PARSE_COMP,
    PARSE_CRC,
    PARSE_DONE
  } parse_phase_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  metadata_header_parser_crc_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned buffers_sent   = 0;

  in_item_t    pending_bytes[$];
  out_item_t   expected_results[$];
  logic [7:0]  hdr_bytes[$];
  logic [31:0] stim_magic;
  logic [31:0] stim_version;

  // parser mirror
  logic [31:0]  pred_magic   = '0;
  logic [31:0]  pred_version = '0;
  parse_phase_e parse_phase;
  int unsigned  field_idx;
  logic [15:0]  name_left;
  logic [63:0]  field_shift;
  logic [31:0]  crc_acc;
  logic [15:0]  hold_nlen;
  logic [63:0]  hold_rows;
  logic [31:0]  hold_cols;
  logic         hold_comp;
  logic         err_seen;

  function automatic logic [31:0] crc32_next(logic [31:0] crc, logic [7:0] d);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[i]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic int unsigned field_bytes(parse_phase_e p);
    case (p)
      PARSE_NLEN: return 2;
      PARSE_ROWS: return 8;
      PARSE_COMP: return 1;
      default:    return 4;
    endcase
  endfunction

  function automatic bit take_idle();
    if (cycle_count >= 400 && cycle_count < 900) return 1'b0;
    return $urandom_range(99) < IdlePct;
  endfunction

  task automatic restart_parse();
    parse_phase = PARSE_MAGIC;
    field_idx   = 0;
    name_left   = '0;
    field_shift = '0;
    crc_acc     = CrcInit;
    hold_nlen   = '0;
    hold_rows   = '0;
    hold_cols   = '0;
    hold_comp   = 1'b0;
    err_seen    = 1'b0;
  endtask

  task automatic predict_parse(in_item_t it);
    out_item_t   res;
    status_e     err;
    logic [63:0] v;
    bit          have_res;
    res      = '0;
    err      = ST_OK;
    have_res = 1'b0;
    if (err_seen || parse_phase == PARSE_DONE) begin
      if (it.last_byte) restart_parse();
      return;
    end
    if (parse_phase != PARSE_CRC) crc_acc = crc32_next(crc_acc, it.data_byte);
    if (parse_phase == PARSE_NAME) begin
      res.kind        = KIND_NAME;
      res.name_char   = it.data_byte;
      res.name_length = hold_nlen;
      have_res        = 1'b1;
      name_left       = name_left - 16'd1;
      if (name_left == 16'd0) parse_phase = PARSE_ROWS;
    end else begin
      field_shift = field_shift | (64'(it.data_byte) << (8 * field_idx));
      field_idx++;
      if (field_idx == field_bytes(parse_phase)) begin
        v           = field_shift;
        field_idx   = 0;
        field_shift = '0;
        case (parse_phase)
          PARSE_MAGIC: begin
            if (v[31:0] != pred_magic) err = ST_BAD_MAGIC;
            else parse_phase = PARSE_VERSION;
          end
          PARSE_VERSION: begin
            if (v[31:0] != pred_version) err = ST_BAD_VERSION;
            else parse_phase = PARSE_NLEN;
          end
          PARSE_NLEN: begin
            hold_nlen   = v[15:0];
            name_left   = v[15:0];
            parse_phase = (v[15:0] != 16'd0) ? PARSE_NAME : PARSE_ROWS;
          end
          PARSE_ROWS: begin
            hold_rows   = v;
            parse_phase = PARSE_COLS;
          end
          PARSE_COLS: begin
            hold_cols   = v[31:0];
            parse_phase = PARSE_COMP;
          end
          PARSE_COMP: begin
            hold_comp   = (v != 64'd0);
            parse_phase = PARSE_CRC;
          end
          default: begin
            res.kind         = KIND_HEADER;
            res.name_length  = hold_nlen;
            res.row_total    = hold_rows;
            res.column_total = hold_cols;
            res.compressed   = hold_comp;
            res.stored_crc   = v[31:0];
            res.checksum_ok  = ((crc_acc ^ CrcXorOut) == v[31:0]);
            have_res         = 1'b1;
            parse_phase      = PARSE_DONE;
          end
        endcase
      end
    end
    if (err == ST_OK && it.last_byte && parse_phase != PARSE_DONE) err = ST_TRUNCATED;
    if (err != ST_OK) begin
      res        = '0;
      res.kind   = KIND_ERROR;
      res.status = err;
      have_res   = 1'b1;
      err_seen   = 1'b1;
    end
    if (have_res) expected_results = {expected_results, res};
    if (it.last_byte) restart_parse();
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string fname, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", fname, got, want));
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_parse(in_data_i);
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && !take_idle()) begin
          in_data_i  <= pending_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d", out_data_o.kind));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 64'(out_data_o.kind), 64'(want.kind));
          check_field("name_char", 64'(out_data_o.name_char), 64'(want.name_char));
          check_field("name_length", 64'(out_data_o.name_length), 64'(want.name_length));
          check_field("row_total", out_data_o.row_total, want.row_total);
          check_field("column_total", 64'(out_data_o.column_total), 64'(want.column_total));
          check_field("compressed", 64'(out_data_o.compressed), 64'(want.compressed));
          check_field("stored_crc", 64'(out_data_o.stored_crc), 64'(want.stored_crc));
          check_field("checksum_ok", 64'(out_data_o.checksum_ok), 64'(want.checksum_ok));
          check_field("status", 64'(out_data_o.status), 64'(want.status));
        end
      end
      out_ready_i <= !take_idle();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MAGIC) pred_magic = val;
    else pred_version = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_le(logic [63:0] v, int unsigned n);
    for (int unsigned i = 0; i < n; i++) hdr_bytes = {hdr_bytes, v[8*i +: 8]};
  endtask

  task automatic make_header(logic [31:0] magic, logic [31:0] version, logic [15:0] nlen,
                             logic [63:0] rows, logic [31:0] cols, logic [7:0] comp,
                             bit corrupt_crc);
    logic [31:0] crc;
    hdr_bytes.delete();
    push_le(64'(magic), 4);
    push_le(64'(version), 4);
    push_le(64'(nlen), 2);
    for (int unsigned i = 0; i < nlen; i++) hdr_bytes = {hdr_bytes, 8'($urandom)};
    push_le(rows, 8);
    push_le(64'(cols), 4);
    hdr_bytes = {hdr_bytes, comp};
    crc = CrcInit;
    foreach (hdr_bytes[k]) crc = crc32_next(crc, hdr_bytes[k]);
    crc = crc ^ CrcXorOut;
    if (corrupt_crc) crc = crc ^ (32'd1 << $urandom_range(31));
    push_le(64'(crc), 4);
  endtask

  // queue the first keep bytes as one buffer
  task automatic send_bytes(int unsigned keep);
    in_item_t it;
    for (int unsigned k = 0; k < keep; k++) begin
      it.data_byte = hdr_bytes[k];
      it.last_byte = (k == keep - 1);
      pending_bytes = {pending_bytes, it};
    end
    buffers_sent++;
  endtask

  function automatic logic [63:0] pick_wide();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] pick_comp();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_nlen();
    if ($urandom_range(9) == 0) return 16'($urandom_range(40));
    return 16'($urandom_range(6));
  endfunction

  task automatic make_random_header(logic [31:0] magic, logic [31:0] version,
                                    logic [15:0] nlen, bit corrupt_crc);
    logic [63:0] cols;
    cols = pick_wide();
    make_header(magic, version, nlen, pick_wide(), cols[31:0], pick_comp(), corrupt_crc);
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned keep;
    logic [15:0] nlen;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        make_random_header(stim_magic, stim_version, pick_nlen(), $urandom_range(3) == 0);
        repeat ($urandom_range(3)) hdr_bytes = {hdr_bytes, 8'($urandom)};
        keep = hdr_bytes.size();
      end else if (pick < 70) begin
        nlen = ($urandom_range(19) == 0) ? 16'hFFFF : pick_nlen();
        make_random_header(stim_magic, stim_version, nlen, 1'b0);
        if (nlen == 16'hFFFF) keep = $urandom_range(16, 1);
        else keep = $urandom_range(hdr_bytes.size() - 1, 1);
      end else if (pick < 80) begin
        make_random_header(stim_magic ^ (32'd1 << $urandom_range(31)), stim_version,
                           pick_nlen(), 1'b0);
        keep = $urandom_range(hdr_bytes.size(), 1);
      end else if (pick < 90) begin
        make_random_header(stim_magic, stim_version ^ (32'd1 << $urandom_range(31)),
                           pick_nlen(), 1'b0);
        keep = $urandom_range(hdr_bytes.size(), 1);
      end else begin
        hdr_bytes.delete();
        repeat ($urandom_range(6, 1)) hdr_bytes = {hdr_bytes, 8'($urandom)};
        keep = hdr_bytes.size();
      end
      sent += keep;
      send_bytes(keep);
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    restart_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers still at their reset value
    stim_magic   = '0;
    stim_version = '0;
    hdr_bytes.delete();
    hdr_bytes = {hdr_bytes, 8'hA5};
    send_bytes(1);
    // bad magic wins over truncation on the final byte
    hdr_bytes.delete();
    push_le(64'h1, 4);
    send_bytes(4);
    make_header('0, '0, 16'd0, '1, '1, 8'hFF, 1'b0);
    send_bytes(hdr_bytes.size());
    run_random(PhaseBytes);
    wait_idle();

    for (int unsigned s = 1; s < NumSettings; s++) begin
      case (s)
        1: begin
          stim_magic   = '1;
          stim_version = '1;
        end
        2: begin
          stim_magic   = '0;
          stim_version = '1;
        end
        default: begin
          stim_magic   = $urandom;
          stim_version = $urandom;
        end
      endcase
      write_reg(CFG_MAGIC, stim_magic);
      write_reg(CFG_VERSION, stim_version);
      run_random(PhaseBytes);
      wait_idle();
    end

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Ran %0d buffers (%0d bytes) over %0d magic/version settings; %0d results checked",
             buffers_sent, bytes_accepted, NumSettings, results_seen);
    $display("Covered good and bad CRCs, truncation, bad magic/version, noise and trailing bytes");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
